>>> hw/rtl/bq_pkg.sv
// Package for the biquad IIR filter: sequencer state type, register indexes,
// term step codes and fixed widths of the coefficient datapath.
// No dependencies.
package bq_pkg;

    // Fixed widths of the datapath.
    localparam int COEF_WIDTH = 32;
    localparam int ACC_FRAC   = 24;
    localparam int MUL_WIDTH  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_W     = 3;

    // Defaults for the top-level parameters.
    localparam int DEF_SAMPLE_WIDTH   = 16;
    localparam int DEF_COEF_FRAC_BITS = 28;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_B0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FORM = 3'd5;

    // Filter structure codes.
    localparam logic FORM_DF1  = 1'b0;
    localparam logic FORM_TDF2 = 1'b1;

    // Product term steps; each sample runs through all five.
    localparam logic [STEP_W-1:0] STEP_0 = 3'd0;
    localparam logic [STEP_W-1:0] STEP_1 = 3'd1;
    localparam logic [STEP_W-1:0] STEP_2 = 3'd2;
    localparam logic [STEP_W-1:0] STEP_3 = 3'd3;
    localparam logic [STEP_W-1:0] STEP_4 = 3'd4;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ROUND,
        ST_ACCUM,
        ST_EMIT
    } t_bq_state;

endpackage

>>> hw/rtl/biquad_iir_filter.sv
// Biquad IIR filter top level: config registers, term sequencer, shared
// 32x32 multiplier, rounding, accumulation and output register.
// Depends on bq_pkg.
//
//   channel   | direction | handshake                  | payload
//   ----------+-----------+----------------------------+--------------------------
//   s (input) | in        | i_s_tvalid / o_s_tready    | i_s_tdata: sample_in
//   m (result)| out       | o_m_tvalid / i_m_tready    | o_m_tdata: sample_out,
//             |           |                            | o_m_tuser: clipped
//   cfg       | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Each sample passes from acceptance to the loaded output register through an
// acceptance state, five product terms (each with operand load, low and high
// half through the one shared 32x32 multiplier, rounding, and accumulation),
// and an output state. The input is not ready meanwhile.
// The output register holds a word until it is taken; a finished sample waits
// in the output state while the register is still full. Reset is synchronous
// and restores the coefficient defaults and clears all filter state.
module biquad_iir_filter
    import bq_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    localparam int TD_W          = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input sample stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [TD_W-1:0]       i_s_tdata,    // [SAMPLE_WIDTH-1:0] sample_in
    // Filtered sample stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [TD_W-1:0]       o_m_tdata,    // [SAMPLE_WIDTH-1:0] sample_out
    output logic                  o_m_tuser,    // [0] clipped
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COEF_WIDTH-1:0] i_cfg_data
);

    localparam int ACC_W = SAMPLE_WIDTH + ACC_FRAC;
    localparam int AW    = ACC_W + 3;
    localparam int SH    = COEF_WIDTH - COEF_FRAC_BITS;
    localparam int PW    = 2 * MUL_WIDTH;

    localparam logic [PW-1:0]         LIM      = PW'(1) << (ACC_W - 1);
    localparam logic [PW-1:0]         HI_LIM   = LIM >> SH;
    localparam logic [PW:0]           HALF     = (PW + 1)'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [ACC_W-1:0]      ACC_MAX  = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic [COEF_WIDTH-1:0] B0_RESET = COEF_WIDTH'(1) << COEF_FRAC_BITS;
    localparam logic [ACC_W:0]        OUT_HALF = (ACC_W + 1)'(1) << (ACC_FRAC - 1);

    // Saturate a wide accumulator value to the internal range.
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [AW-1:0] v);
        logic fits;
        fits = (v[AW-1:ACC_W-1] == {(AW - ACC_W + 1){1'b0}})
            || (v[AW-1:ACC_W-1] == {(AW - ACC_W + 1){1'b1}});
        if (fits) begin
            return v[ACC_W-1:0];
        end else if (v[AW-1]) begin
            return {1'b1, {(ACC_W - 1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_W - 1){1'b1}}};
        end
    endfunction

    t_bq_state r_state, n_state;

    // Configuration registers.
    logic signed [COEF_WIDTH-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;
    logic                         r_form;

    // Filter state.
    logic signed [SAMPLE_WIDTH-1:0] r_in_d1, r_in_d2;
    logic signed [ACC_W-1:0]        r_out_d1, r_out_d2;
    logic signed [ACC_W-1:0]        r_ps1, r_ps2;

    // Per-sample working registers.
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic [STEP_W-1:0]              r_step;
    logic [ACC_W-1:0]               r_mag_a;
    logic [COEF_WIDTH-1:0]          r_mag_c;
    logic                           r_neg;
    logic                           r_sub;
    logic [PW-1:0]                  r_prod_lo, r_prod_hi;
    logic [ACC_W-1:0]               r_q;
    logic signed [AW-1:0]           r_acc;
    logic signed [ACC_W-1:0]        r_y;

    // Output register.
    logic                    r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                    r_out_clip;

    // Sequencer controls.
    logic c_accept, c_last_step, c_emit, c_mul_hi;

    // ---------------- Next-state logic ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_s_tvalid) n_state = ST_LOAD;
            ST_LOAD:   n_state = ST_MUL_LO;
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_ROUND;
            ST_ROUND:  n_state = ST_ACCUM;
            ST_ACCUM:  n_state = (r_step == STEP_4) ? ST_EMIT : ST_LOAD;
            ST_EMIT:   if (!r_out_valid || i_m_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // ---------------- Sequencer outputs ----------------
    always_comb begin
        c_accept    = 1'b0;
        c_last_step = 1'b0;
        c_emit      = 1'b0;
        c_mul_hi    = 1'b0;
        unique case (r_state)
            ST_IDLE:   c_accept = i_s_tvalid;
            ST_MUL_HI: c_mul_hi = 1'b1;
            ST_ACCUM:  c_last_step = (r_step == STEP_4);
            ST_EMIT:   c_emit = !r_out_valid || i_m_tready;
            default: begin
            end
        endcase
    end

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- Configuration writes ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0   <= B0_RESET;
            r_b1   <= '0;
            r_b2   <= '0;
            r_a1   <= '0;
            r_a2   <= '0;
            r_form <= FORM_TDF2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_B0:   r_b0   <= i_cfg_data;
                REG_B1:   r_b1   <= i_cfg_data;
                REG_B2:   r_b2   <= i_cfg_data;
                REG_A1:   r_a1   <= i_cfg_data;
                REG_A2:   r_a2   <= i_cfg_data;
                REG_FORM: r_form <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- Term operand selection ----------------
    logic signed [ACC_W-1:0]      x_acc, d1_acc, d2_acc, op_a;
    logic signed [COEF_WIDTH-1:0] op_c;
    logic                         op_sub;

    assign x_acc  = {r_x, {ACC_FRAC{1'b0}}};
    assign d1_acc = {r_in_d1, {ACC_FRAC{1'b0}}};
    assign d2_acc = {r_in_d2, {ACC_FRAC{1'b0}}};

    // Direct form 1 runs b0 x, b1 x1, b2 x2, a1 y1, a2 y2. The transposed
    // form runs b0 x, then b1 x and a1 y for the first partial sum, then
    // b2 x and a2 y for the second.
    always_comb begin
        op_a   = x_acc;
        op_c   = r_b0;
        op_sub = 1'b0;
        if (r_form == FORM_DF1) begin
            unique case (r_step)
                STEP_0: begin op_a = x_acc;    op_c = r_b0; op_sub = 1'b0; end
                STEP_1: begin op_a = d1_acc;   op_c = r_b1; op_sub = 1'b0; end
                STEP_2: begin op_a = d2_acc;   op_c = r_b2; op_sub = 1'b0; end
                STEP_3: begin op_a = r_out_d1; op_c = r_a1; op_sub = 1'b1; end
                STEP_4: begin op_a = r_out_d2; op_c = r_a2; op_sub = 1'b1; end
                default: begin end
            endcase
        end else begin
            unique case (r_step)
                STEP_0: begin op_a = x_acc; op_c = r_b0; op_sub = 1'b0; end
                STEP_1: begin op_a = x_acc; op_c = r_b1; op_sub = 1'b0; end
                STEP_2: begin op_a = r_y;   op_c = r_a1; op_sub = 1'b1; end
                STEP_3: begin op_a = x_acc; op_c = r_b2; op_sub = 1'b0; end
                STEP_4: begin op_a = r_y;   op_c = r_a2; op_sub = 1'b1; end
                default: begin end
            endcase
        end
    end

    // ---------------- Shared multiplier ----------------
    logic [PW-1:0]        mag_a_ext;
    logic [MUL_WIDTH-1:0] mul_a;
    logic [PW-1:0]        mul_p;

    assign mag_a_ext = PW'(r_mag_a);
    assign mul_a     = c_mul_hi ? mag_a_ext[PW-1:MUL_WIDTH] : mag_a_ext[MUL_WIDTH-1:0];
    assign mul_p     = PW'(mul_a) * PW'(r_mag_c);

    // ---------------- Product rounding ----------------
    // Magnitude rounded half up, which is half away from zero on the signed
    // product, then limited to one past the largest internal value.
    logic [PW:0]   lo_rnd, lo_q;
    logic [PW-1:0] q_sum;
    logic [PW-1:0] q_sat;

    assign lo_rnd = {1'b0, r_prod_lo} + HALF;
    assign lo_q   = lo_rnd >> COEF_FRAC_BITS;
    assign q_sum  = (r_prod_hi << SH) + lo_q[PW-1:0];
    assign q_sat  = ((r_prod_hi > HI_LIM) || (q_sum > LIM)) ? LIM : q_sum;

    // ---------------- Accumulation ----------------
    logic [ACC_W-1:0]        q_pos;
    logic signed [ACC_W:0]   term_s;
    logic signed [AW-1:0]    term_w, acc_sum;
    logic signed [ACC_W-1:0] acc_sat;

    assign q_pos   = (r_q > ACC_MAX) ? ACC_MAX : r_q;
    assign term_s  = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, q_pos});
    assign term_w  = AW'(term_s);
    assign acc_sum = r_sub ? (r_acc - term_w) : (r_acc + term_w);
    assign acc_sat = sat_acc(acc_sum);

    // Working registers for one sample.
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_x    <= i_s_tdata[SAMPLE_WIDTH-1:0];
            r_step <= STEP_0;
            r_acc  <= (r_form == FORM_TDF2) ? AW'(r_ps1) : '0;
        end
        if (r_state == ST_LOAD) begin
            r_mag_a <= op_a[ACC_W-1] ? (~op_a + 1'b1) : op_a;
            r_mag_c <= op_c[COEF_WIDTH-1] ? (~op_c + 1'b1) : op_c;
            r_neg   <= op_a[ACC_W-1] ^ op_c[COEF_WIDTH-1];
            r_sub   <= op_sub;
        end
        if (r_state == ST_MUL_LO) begin
            r_prod_lo <= mul_p;
        end
        if (r_state == ST_MUL_HI) begin
            r_prod_hi <= mul_p;
        end
        if (r_state == ST_ROUND) begin
            r_q <= q_sat[ACC_W-1:0];
        end
        if (r_state == ST_ACCUM) begin
            r_step <= r_step + 1'b1;
            if (r_form == FORM_DF1) begin
                r_acc <= acc_sum;
                if (c_last_step) begin
                    r_y <= acc_sat;
                end
            end else begin
                // The output closes after the first term; the second partial
                // sum seeds the first, and the second starts from zero.
                if (r_step == STEP_0) begin
                    r_y   <= acc_sat;
                    r_acc <= AW'(r_ps2);
                end else if (r_step == STEP_2) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= acc_sum;
                end
            end
        end
    end

    // Filter state, updated as each structure closes its sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_d1  <= '0;
            r_in_d2  <= '0;
            r_out_d1 <= '0;
            r_out_d2 <= '0;
            r_ps1    <= '0;
            r_ps2    <= '0;
        end else if (r_state == ST_ACCUM) begin
            if (r_form == FORM_DF1) begin
                if (c_last_step) begin
                    r_in_d2  <= r_in_d1;
                    r_in_d1  <= r_x;
                    r_out_d2 <= r_out_d1;
                    r_out_d1 <= acc_sat;
                end
            end else begin
                if (r_step == STEP_2) begin
                    r_ps1 <= acc_sat;
                end else if (c_last_step) begin
                    r_ps2 <= acc_sat;
                end
            end
        end
    end

    // ---------------- Output rounding and saturation ----------------
    // Round half toward plus infinity, then clamp to the sample range.
    logic signed [ACC_W:0]        y_rnd;
    logic signed [SAMPLE_WIDTH:0] y_int;
    logic                         y_fits;
    logic [SAMPLE_WIDTH-1:0]      y_out;

    assign y_rnd  = (ACC_W + 1)'(r_y) + $signed(OUT_HALF);
    assign y_int  = y_rnd[ACC_W:ACC_FRAC];
    assign y_fits = (y_int[SAMPLE_WIDTH] == y_int[SAMPLE_WIDTH-1]);
    assign y_out  = y_fits ? y_int[SAMPLE_WIDTH-1:0]
                  : (y_int[SAMPLE_WIDTH] ? {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}}
                                         : {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}});

    // Output register; a new word loads as the previous one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_emit) begin
            r_out_sample <= y_out;
            r_out_clip   <= !y_fits;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TD_W'(r_out_sample);
    assign o_m_tuser  = r_out_clip;

endmodule

>>> tb/biquad_iir_filter_test.sv
// Self-checking testbench for the biquad IIR filter: drives sample and config
// streams, predicts each filtered sample and compares it with the output stream.
// Depends on bq_pkg and the biquad_iir_filter RTL.
`timescale 1ns / 100ps

module biquad_iir_filter_test;
    import bq_pkg::*;

    localparam int SAMPLE_W  = DEF_SAMPLE_WIDTH;
    localparam int FRAC_BITS = DEF_COEF_FRAC_BITS;
    localparam int TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;
    localparam int ACC_W     = SAMPLE_W + ACC_FRAC;

    localparam longint      ACC_MAX  = (64'sd1 <<< (ACC_W - 1)) - 1;
    localparam longint      ACC_MIN  = -ACC_MAX - 1;
    localparam logic [79:0] ACC_LIM  = 80'd1 << (ACC_W - 1);
    localparam longint      ACC_ONE  = 64'sd1 <<< ACC_FRAC;
    localparam longint      ACC_HALF = 64'sd1 <<< (ACC_FRAC - 1);
    localparam longint      SMP_MAX  = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint      SMP_MIN  = -SMP_MAX - 1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI = SAMPLE_W'(SMP_MAX);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO = SAMPLE_W'(SMP_MIN);

    // Coefficient values used by the directed tests (Q3.28).
    localparam logic [COEF_WIDTH-1:0] COEF_MAX      = 32'h7FFF_FFFF;
    localparam logic [COEF_WIDTH-1:0] COEF_MIN      = 32'h8000_0000;
    localparam logic [COEF_WIDTH-1:0] COEF_ZERO     = 32'h0000_0000;
    localparam logic [COEF_WIDTH-1:0] COEF_ONE      = 32'h1000_0000;
    localparam logic [COEF_WIDTH-1:0] COEF_HALF     = 32'h0800_0000;
    // Makes a unit sample produce exactly half an internal LSB.
    localparam logic [COEF_WIDTH-1:0] COEF_HALF_LSB = 32'h0000_0008;

    // Register indexes that the block decodes to nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    localparam int     TOTAL_SAMPLES = 1650;
    localparam int     LONG_HOLD     = 400;
    localparam longint CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } t_filtered;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE,
        READY_MOSTLY
    } t_ready_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [TDATA_W-1:0]    i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [TDATA_W-1:0]    o_m_tdata;
    logic                  o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [COEF_WIDTH-1:0] i_cfg_data  = '0;

    // Predictor copy of the configuration.
    logic signed [COEF_WIDTH-1:0] cur_b0 = COEF_ONE;
    logic signed [COEF_WIDTH-1:0] cur_b1 = COEF_ZERO;
    logic signed [COEF_WIDTH-1:0] cur_b2 = COEF_ZERO;
    logic signed [COEF_WIDTH-1:0] cur_a1 = COEF_ZERO;
    logic signed [COEF_WIDTH-1:0] cur_a2 = COEF_ZERO;
    logic                         cur_form = FORM_TDF2;

    // Predictor copy of the filter history.
    logic signed [SAMPLE_W-1:0] x_hist1 = '0;
    logic signed [SAMPLE_W-1:0] x_hist2 = '0;
    logic signed [ACC_W-1:0]    y_hist1 = '0;
    logic signed [ACC_W-1:0]    y_hist2 = '0;
    logic signed [ACC_W-1:0]    tdf_s1  = '0;
    logic signed [ACC_W-1:0]    tdf_s2  = '0;

    t_filtered   awaited_outputs[$];
    int unsigned errors       = 0;
    int unsigned samples_sent = 0;
    int unsigned burst_left   = 0;
    bit          gaps_on      = 1'b1;
    int unsigned hold_token   = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;
    int unsigned stall_span   = 0;
    t_ready_mode stall_mode   = READY_ALWAYS;
    longint      cycle_count  = 0;

    biquad_iir_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),    // [15:0] sample_in
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),    // [15:0] sample_out
        .o_m_tuser   (o_m_tuser),    // [0] clipped
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Product of an internal value and a coefficient, scaled back by the
    // coefficient fraction bits, rounded half away from zero and clamped.
    function automatic longint coef_mul(longint v, logic signed [COEF_WIDTH-1:0] c);
        longint      cv;
        bit          neg;
        logic [79:0] mag;
        logic [79:0] q;
        cv  = c;
        neg = (v < 0) != (cv < 0);
        mag = 80'(v < 0 ? -v : v) * 80'(cv < 0 ? -cv : cv);
        q   = (mag + (80'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (q > ACC_LIM) q = ACC_LIM;
        if (neg) return -longint'(q);
        return (q > ACC_MAX) ? ACC_MAX : longint'(q);
    endfunction

    function automatic longint clamp_acc(longint v);
        if (v > ACC_MAX) return ACC_MAX;
        if (v < ACC_MIN) return ACC_MIN;
        return v;
    endfunction

    // Filters one sample through the selected structure and updates its history.
    function automatic t_filtered run_biquad(logic signed [SAMPLE_W-1:0] x);
        longint    xa;
        longint    y;
        longint    q;
        t_filtered r;
        xa = longint'(x) * ACC_ONE;
        if (cur_form == FORM_DF1) begin
            y = clamp_acc(coef_mul(xa, cur_b0)
                          + coef_mul(longint'(x_hist1) * ACC_ONE, cur_b1)
                          + coef_mul(longint'(x_hist2) * ACC_ONE, cur_b2)
                          - coef_mul(y_hist1, cur_a1) - coef_mul(y_hist2, cur_a2));
            x_hist2 = x_hist1;
            x_hist1 = x;
            y_hist2 = y_hist1;
            y_hist1 = y;
        end else begin
            y = clamp_acc(coef_mul(xa, cur_b0) + tdf_s1);
            tdf_s1 = clamp_acc(coef_mul(xa, cur_b1) - coef_mul(y, cur_a1) + tdf_s2);
            tdf_s2 = clamp_acc(coef_mul(xa, cur_b2) - coef_mul(y, cur_a2));
        end
        // Round half up to an integer sample, then saturate.
        q = (y + ACC_HALF) >>> ACC_FRAC;
        r.clipped = 1'b0;
        if (q > SMP_MAX) begin
            q = SMP_MAX;
            r.clipped = 1'b1;
        end
        if (q < SMP_MIN) begin
            q = SMP_MIN;
            r.clipped = 1'b1;
        end
        r.sample = q[SAMPLE_W-1:0];
        return r;
    endfunction

    // Stops offering samples and waits for every awaited output word.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (awaited_outputs.size() != 0);
    endtask

    // Offers one sample word; gaps open between bursts of random length.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = 0;
            if (gaps_on)
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                                  : $urandom_range(0, 4);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                i_s_tdata  <= TDATA_W'($urandom());
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= x;
        do @(posedge i_clk); while (!o_s_tready);
        awaited_outputs.push_back(run_biquad(x));
        samples_sent++;
    endtask

    // Writes one register once the filter is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COEF_WIDTH-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_B0:   cur_b0 = value;
            REG_B1:   cur_b1 = value;
            REG_B2:   cur_b2 = value;
            REG_A1:   cur_a1 = value;
            REG_A2:   cur_a2 = value;
            REG_FORM: cur_form = value[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [COEF_WIDTH-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return COEF_ZERO;
            3, 4, 5, 6: return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_LO;
            1: return SAMPLE_HI;
            2, 3: return SAMPLE_W'($urandom_range(0, 512) - 256);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Pass-through with the reset coefficients, sample extremes included.
    task automatic test_reset_defaults();
        gaps_on = 1'b1;
        send_sample(SAMPLE_W'(0));
        send_sample(SAMPLE_HI);
        send_sample(SAMPLE_LO);
        send_sample(SAMPLE_W'(1));
        send_sample(SAMPLE_W'(-1));
    endtask

    // Largest and smallest gain, and both rounding steps at their half points.
    task automatic test_coef_extremes();
        write_reg(REG_B0, COEF_MAX);
        send_sample(SAMPLE_HI);
        send_sample(SAMPLE_LO);
        write_reg(REG_B0, COEF_MIN);
        send_sample(SAMPLE_LO);
        send_sample(SAMPLE_HI);
        write_reg(REG_B0, COEF_HALF);
        send_sample(SAMPLE_W'(1));
        send_sample(SAMPLE_W'(-1));
        send_sample(SAMPLE_W'(3));
        send_sample(SAMPLE_W'(-3));
        write_reg(REG_B0, COEF_HALF_LSB);
        send_sample(SAMPLE_W'(1));
        send_sample(SAMPLE_W'(-1));
    endtask

    // Runaway feedback into internal saturation, undecoded indexes, and
    // switching forms back and forth so each resumes its own history.
    task automatic test_feedback_saturation();
        write_reg(REG_B0, COEF_ONE);
        write_reg(REG_B1, COEF_MAX);
        write_reg(REG_B2, COEF_MIN);
        write_reg(REG_A1, COEF_MIN);
        write_reg(REG_A2, COEF_MAX);
        write_reg(REG_FORM, COEF_WIDTH'(FORM_DF1));
        write_reg(REG_UNUSED_LO, $urandom());
        write_reg(REG_UNUSED_HI, $urandom());
        send_sample(SAMPLE_W'(1000));
        send_sample(SAMPLE_LO);
        send_sample(SAMPLE_HI);
        send_sample(SAMPLE_W'(0));
        write_reg(REG_FORM, COEF_WIDTH'(FORM_TDF2));
        send_sample(SAMPLE_W'(100));
        send_sample(SAMPLE_W'(-100));
        send_sample(SAMPLE_W'(0));
        write_reg(REG_FORM, COEF_WIDTH'(FORM_DF1));
        send_sample(SAMPLE_W'(7));
        send_sample(SAMPLE_W'(-7));
    endtask

    // The output side holds off while samples keep coming, so the input stalls.
    task automatic test_output_stall();
        write_reg(REG_B0, COEF_HALF);
        write_reg(REG_A1, COEF_ZERO);
        write_reg(REG_A2, COEF_ZERO);
        gaps_on = 1'b0;
        hold_token++;
        repeat (20) send_sample(pick_sample());
        wait_drained();
        gaps_on = 1'b1;
    endtask

    // Random filter settings, each followed by a run of random samples.
    task automatic test_random_filters();
        logic [CFG_IDX_W-1:0] idx;
        while (samples_sent < TOTAL_SAMPLES) begin
            idx = REG_B0;
            repeat (5) begin
                if ($urandom_range(0, 2) != 0) write_reg(idx, pick_coef());
                idx++;
            end
            if ($urandom_range(0, 1) != 0) write_reg(REG_FORM, $urandom());
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO, $urandom());
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(10, 60)) send_sample(pick_sample());
        end
    endtask

    // Output ready follows a changing pattern, with an occasional long hold.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            if (stall_span == 0) begin
                stall_mode = t_ready_mode'($urandom_range(0, 3));
                stall_span = $urandom_range(20, 200);
            end
            stall_span--;
            case (stall_mode)
                READY_ALWAYS: i_m_tready <= 1'b1;
                READY_RANDOM: i_m_tready <= ($urandom_range(0, 1) != 0);
                READY_SPARSE: i_m_tready <= (stall_span % 5 == 0);
                default:      i_m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Each output word is compared with the oldest awaited result.
    always @(posedge i_clk) begin : check_output
        t_filtered want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (awaited_outputs.size() == 0) begin
                $display("%0t: output word %0d with no sample pending", $time,
                         $signed(o_m_tdata[SAMPLE_W-1:0]));
                errors++;
            end else begin
                want = awaited_outputs.pop_front();
                if (o_m_tdata[SAMPLE_W-1:0] !== want.sample) begin
                    $display("%0t: sample_out expected %0d, got %0d", $time,
                             want.sample, $signed(o_m_tdata[SAMPLE_W-1:0]));
                    errors++;
                end
                if (o_m_tuser !== want.clipped) begin
                    $display("%0t: clipped expected %0b, got %0b", $time,
                             want.clipped, o_m_tuser);
                    errors++;
                end
            end
        end
    end

    // Guards against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** biquad_iir_filter: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_coef_extremes();
        test_feedback_saturation();
        test_output_stall();
        test_random_filters();
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (errors == 0)
            $display("** biquad_iir_filter: PASSED **");
        else
            $display("** biquad_iir_filter: FAILED **");
        $finish;
    end

endmodule
